FILE: src/scba_pkg.sv
// Package for the size-class block allocator: codes, fixed widths, defaults
// and the block descriptor word. No dependencies.
`timescale 1ns / 1ps
package scba_pkg;

  localparam int DEF_NUM_CLASSES     = 10;
  localparam int DEF_MIN_BLOCK_BYTES = 32;
  localparam int DEF_HEADER_BYTES    = 16;
  localparam int DEF_POOL_CHUNKS     = 64;

  localparam int IDX_W       = 15;
  localparam int BLOCK_DEPTH = 32768;
  localparam int ADDR_W      = 20;
  localparam int ADDR_SPACE  = 1048576;
  localparam int REQ_W       = 32;
  localparam int COPY_W      = 14;
  localparam int CLS_W       = 4;
  localparam int USED_W      = 8;

  localparam logic [1:0] K_ALLOC   = 2'd0;
  localparam logic [1:0] K_FREE    = 2'd1;
  localparam logic [1:0] K_REALLOC = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_MEM    = 2'd2;
  localparam logic [1:0] ST_INVALID   = 2'd3;

  // One descriptor per block slot.
  typedef struct packed {
    logic              live;
    logic [CLS_W-1:0]  cls;
    logic [USED_W-1:0] used;
    logic [IDX_W-1:0]  nxt;
  } blk_word_t;

endpackage

FILE: src/scba_if.sv
// Request and response channel interfaces of the block allocator.
// Depends on scba_pkg.
`timescale 1ns / 1ps
interface scba_req_if import scba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [ADDR_W-1:0] address;
  logic [REQ_W-1:0]  request_size;
  modport source (output valid, kind, address, request_size, input ready);
  modport sink   (input valid, kind, address, request_size, output ready);
endinterface

interface scba_rsp_if import scba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] result_address;
  logic [COPY_W-1:0] copy_bytes;
  logic [CLS_W-1:0]  size_class;
  modport source (output valid, status, result_address, copy_bytes, size_class, input ready);
  modport sink   (input valid, status, result_address, copy_bytes, size_class, output ready);
endinterface

FILE: src/scba_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module scba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/size_class_block_allocator_unit.sv
// Size-class block allocator, top level.
// Depends on scba_pkg, scba_if (scba_req_if, scba_rsp_if) and scba_ram.
//
// Usage:
//   in_req carries one request: kind (allocate, free, reallocate), a user
//   address and a byte count. out_rsp returns exactly one response per
//   request: status, granted user address, bytes to copy and size class.
//   Both channels use valid/ready; a request is taken on valid & ready.
//   Requests are worked one at a time. All block descriptors sit in one
//   RAM with a registered read port; each step reads or writes at most one
//   descriptor, so the descriptor port sets the rate.
//   A split links the new blocks of the class one by one, up to
//   2^(NUM_CLASSES-1) of them (512 by default); splitting a larger free
//   block also passes through S_SPOP and S_PRD, a fresh chunk through S_PRD.
//   After reset all 32768 descriptor RAM entries are cleared, one entry a
//   cycle, while in_req.ready stays low.
//   The response sits in an output register; a new request is accepted
//   while it waits, and only the next response waits on out_rsp.ready.
`timescale 1ns / 1ps
module size_class_block_allocator_unit import scba_pkg::*; #(
  parameter int NUM_CLASSES     = DEF_NUM_CLASSES,
  parameter int MIN_BLOCK_BYTES = DEF_MIN_BLOCK_BYTES,
  parameter int HEADER_BYTES    = DEF_HEADER_BYTES,
  parameter int POOL_CHUNKS     = DEF_POOL_CHUNKS
) (
  input  logic      clk,
  input  logic      rst_n,
  scba_req_if.sink  in_req,
  scba_rsp_if.source out_rsp
);

  localparam int CW          = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int KW          = NUM_CLASSES;
  localparam int MIN_SHIFT   = $clog2(MIN_BLOCK_BYTES);
  localparam int BPC_SHIFT   = NUM_CLASSES - 1;
  localparam int CHUNK_BYTES = MIN_BLOCK_BYTES << BPC_SHIFT;
  localparam int LIM1        = BLOCK_DEPTH >> BPC_SHIFT;
  localparam int LIM2        = (ADDR_SPACE - 1 + MIN_BLOCK_BYTES - HEADER_BYTES) / CHUNK_BYTES;
  localparam int LIM12       = (LIM1 < LIM2) ? LIM1 : LIM2;
  localparam int FRESH_LIMIT = (POOL_CHUNKS < LIM12) ? POOL_CHUNKS : LIM12;
  localparam int FW          = $clog2(POOL_CHUNKS + 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_OLD   = 4'd3;
  localparam logic [3:0] S_ADEC  = 4'd4;
  localparam logic [3:0] S_SPOP  = 4'd5;
  localparam logic [3:0] S_SPLIT = 4'd6;
  localparam logic [3:0] S_PRD   = 4'd7;
  localparam logic [3:0] S_POP   = 4'd8;
  localparam logic [3:0] S_PUSH  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  clr_r, clr_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  blk_word_t         old_r, old_nxt;
  logic [CW-1:0]     oc_r, oc_nxt;
  logic [CW-1:0]     c_r, c_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [IDX_W-1:0]  base_r, base_nxt;
  logic [IDX_W-1:0]  at_r, at_nxt;
  logic [KW-1:0]     left_r, left_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [FW-1:0]     fresh_r, fresh_nxt;
  logic              moving_r, moving_nxt;
  logic [IDX_W-1:0]  head_r [NUM_CLASSES];
  logic [IDX_W-1:0]  head_nxt [NUM_CLASSES];
  logic [15:0]       cnt_r [NUM_CLASSES];
  logic [15:0]       cnt_nxt [NUM_CLASSES];

  logic [1:0]        res_status_r, res_status_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [COPY_W-1:0] res_copy_r, res_copy_nxt;
  logic [CLS_W-1:0]  res_cls_r, res_cls_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [COPY_W-1:0] out_copy_r, out_copy_nxt;
  logic [CLS_W-1:0]  out_cls_r, out_cls_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  blk_word_t         ram_wdata, ram_rdata;

  logic [4:0]        shift_tab [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] nz;
  logic [CW-1:0]     hsel, c_calc, n_calc, oc_calc;
  logic              n_found, fresh_ok, out_load, accept;
  logic [IDX_W-1:0]  head_sel, step;
  logic [33:0]       size_w, lo_w, hi_w, cap_w, cp_w;
  logic [ADDR_W-1:0] off_w;

  // Scale shift per class: smallest s with (class bytes - header) >> s <= 255.
  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_shift
    localparam int V = (MIN_BLOCK_BYTES << g) - HEADER_BYTES;
    localparam int L = $clog2(V + 1);
    assign shift_tab[g] = 5'((L > 8) ? (L - 8) : 0);
    assign nz[g] = (cnt_r[g] != 16'd0);
  end

  scba_ram #(.WIDTH($bits(blk_word_t)), .DEPTH(BLOCK_DEPTH)) u_desc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept   = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_rsp.ready);

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = out_status_r;
  assign out_rsp.result_address = out_addr_r;
  assign out_rsp.copy_bytes     = out_copy_r;
  assign out_rsp.size_class     = out_cls_r;

  assign size_w   = {2'b00, req_r} + 34'(HEADER_BYTES);
  assign off_w    = addr_r - ADDR_W'(HEADER_BYTES);
  assign fresh_ok = (32'(fresh_r) < 32'(FRESH_LIMIT));
  assign step     = IDX_W'(1) << c_r;
  assign oc_calc  = (ram_rdata.cls >= CLS_W'(NUM_CLASSES)) ? '0 : CW'(ram_rdata.cls);
  assign head_sel = head_r[hsel];

  // Smallest fitting class, and largest non-empty class above it.
  always_comb begin
    c_calc  = CW'(NUM_CLASSES - 1);
    n_calc  = '0;
    n_found = 1'b0;
    for (int i = NUM_CLASSES - 2; i >= 0; i--) begin
      if ((34'(MIN_BLOCK_BYTES) << i) >= size_w) c_calc = CW'(i);
    end
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (CW'(i) > c_calc && nz[i]) begin
        n_calc  = CW'(i);
        n_found = 1'b1;
      end
    end
  end

  always_comb begin
    case (state_r)
      S_ADEC:           hsel = nz[c_calc] ? c_calc : n_calc;
      S_SPOP:           hsel = n_r;
      S_OLD:            hsel = oc_calc;
      S_PUSH:           hsel = oc_r;
      default:          hsel = c_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;   clr_nxt = clr_r;     kind_nxt = kind_r;
    addr_nxt = addr_r;     req_nxt = req_r;     idx_nxt = idx_r;
    old_nxt = old_r;       oc_nxt = oc_r;       c_nxt = c_r;
    n_nxt = n_r;           base_nxt = base_r;   at_nxt = at_r;
    left_nxt = left_r;     k_nxt = k_r;         fresh_nxt = fresh_r;
    moving_nxt = moving_r;
    head_nxt = head_r;     cnt_nxt = cnt_r;
    res_status_nxt = res_status_r; res_addr_nxt = res_addr_r;
    res_copy_nxt = res_copy_r;     res_cls_nxt = res_cls_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r; out_addr_nxt = out_addr_r;
    out_copy_nxt = out_copy_r;     out_cls_nxt = out_cls_r;
    ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0; ram_raddr = '0;
    lo_w = '0; hi_w = '0; cap_w = '0; cp_w = '0;

    case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == IDX_W'(BLOCK_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          kind_nxt = in_req.kind;
          addr_nxt = in_req.address;
          req_nxt  = in_req.request_size;
          res_status_nxt = ST_OK; res_addr_nxt = '0;
          res_copy_nxt = '0;      res_cls_nxt = '0;
          moving_nxt = 1'b0;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (kind_r == K_ALLOC || (kind_r == K_REALLOC && addr_r == '0)) begin
          state_nxt = S_ADEC;
        end else if (kind_r == K_FREE || kind_r == K_REALLOC) begin
          if (kind_r == K_FREE && addr_r == '0) begin
            state_nxt = S_DONE;
          end else if (addr_r < ADDR_W'(HEADER_BYTES) ||
                       off_w[MIN_SHIFT-1:0] != '0 ||
                       (off_w >> MIN_SHIFT) > ADDR_W'(BLOCK_DEPTH - 1)) begin
            res_status_nxt = ST_INVALID;
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = IDX_W'(off_w >> MIN_SHIFT);
            ram_raddr = IDX_W'(off_w >> MIN_SHIFT);
            state_nxt = S_OLD;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_OLD: begin
        hi_w = 34'(MIN_BLOCK_BYTES) << oc_calc;
        lo_w = (oc_calc != '0) ? (34'(MIN_BLOCK_BYTES) << (oc_calc - 1'b1)) : '0;
        if (!ram_rdata.live) begin
          res_status_nxt = ST_INVALID;
          state_nxt = S_DONE;
        end else if (kind_r == K_FREE) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r;
          ram_wdata = '{live: 1'b0, cls: ram_rdata.cls, used: ram_rdata.used, nxt: head_sel};
          head_nxt[hsel] = idx_r;
          cnt_nxt[hsel]  = cnt_r[hsel] + 1'b1;
          state_nxt = S_DONE;
        end else if (size_w > lo_w && size_w <= hi_w) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r;
          ram_wdata = ram_rdata;
          ram_wdata.used = USED_W'(req_r >> shift_tab[oc_calc]);
          res_addr_nxt = addr_r;
          res_cls_nxt  = CLS_W'(oc_calc);
          state_nxt = S_DONE;
        end else begin
          old_nxt    = ram_rdata;
          oc_nxt     = oc_calc;
          moving_nxt = 1'b1;
          state_nxt  = S_ADEC;
        end
      end
      S_ADEC: begin
        c_nxt = c_calc;
        n_nxt = n_calc;
        if (size_w > 34'(CHUNK_BYTES)) begin
          res_status_nxt = ST_TOO_LARGE;
          state_nxt = S_DONE;
        end else if (nz[c_calc]) begin
          ram_raddr = head_sel;
          state_nxt = S_POP;
        end else if (n_found) begin
          ram_raddr = head_sel;
          state_nxt = S_SPOP;
        end else if (fresh_ok) begin
          base_nxt  = IDX_W'(fresh_r) << BPC_SHIFT;
          at_nxt    = IDX_W'(fresh_r) << BPC_SHIFT;
          left_nxt  = KW'(1) << (CW'(NUM_CLASSES - 1) - c_calc);
          k_nxt     = KW'(1) << (CW'(NUM_CLASSES - 1) - c_calc);
          fresh_nxt = fresh_r + 1'b1;
          state_nxt = S_SPLIT;
        end else begin
          res_status_nxt = ST_NO_MEM;
          state_nxt = S_DONE;
        end
      end
      S_SPOP: begin
        head_nxt[hsel] = ram_rdata.nxt;
        cnt_nxt[hsel]  = cnt_r[hsel] - 1'b1;
        base_nxt = head_sel;
        at_nxt   = head_sel;
        left_nxt = KW'(1) << (n_r - c_r);
        k_nxt    = KW'(1) << (n_r - c_r);
        state_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        // Link one block of the new class per cycle.
        ram_we    = 1'b1;
        ram_waddr = at_r;
        ram_wdata = '{live: 1'b0, cls: CLS_W'(c_r), used: '0,
                      nxt: (left_r > KW'(1)) ? (at_r + step) : '0};
        at_nxt   = at_r + step;
        left_nxt = left_r - 1'b1;
        if (left_r == KW'(1)) begin
          head_nxt[hsel] = base_r;
          cnt_nxt[hsel]  = 16'(k_r);
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        ram_raddr = head_sel;
        state_nxt = S_POP;
      end
      S_POP: begin
        head_nxt[hsel] = ram_rdata.nxt;
        cnt_nxt[hsel]  = cnt_r[hsel] - 1'b1;
        ram_we    = 1'b1;
        ram_waddr = head_sel;
        ram_wdata = '{live: 1'b1, cls: CLS_W'(c_r),
                      used: USED_W'(req_r >> shift_tab[c_r]), nxt: ram_rdata.nxt};
        res_addr_nxt = ADDR_W'((32'(head_sel) << MIN_SHIFT) + 32'(HEADER_BYTES));
        res_cls_nxt  = CLS_W'(c_r);
        if (moving_r) begin
          cap_w = (34'(MIN_BLOCK_BYTES) << oc_r) - 34'(HEADER_BYTES);
          cp_w  = (34'(old_r.used) + 34'd1) << shift_tab[oc_r];
          if (cp_w > cap_w) cp_w = cap_w;
          if (cp_w > 34'(req_r)) cp_w = 34'(req_r);
          res_copy_nxt = COPY_W'(cp_w);
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PUSH: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = '{live: 1'b0, cls: old_r.cls, used: old_r.used, nxt: head_sel};
        head_nxt[hsel] = idx_r;
        cnt_nxt[hsel]  = cnt_r[hsel] + 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          out_copy_nxt   = res_copy_r;
          out_cls_nxt    = res_cls_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      fresh_r     <= '0;
      moving_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      fresh_r     <= fresh_nxt;
      moving_r    <= moving_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
    end
    kind_r <= kind_nxt;   addr_r <= addr_nxt;   req_r <= req_nxt;
    idx_r <= idx_nxt;     old_r <= old_nxt;     oc_r <= oc_nxt;
    c_r <= c_nxt;         n_r <= n_nxt;         base_r <= base_nxt;
    at_r <= at_nxt;       left_r <= left_nxt;   k_r <= k_nxt;
    res_status_r <= res_status_nxt; res_addr_r <= res_addr_nxt;
    res_copy_r <= res_copy_nxt;     res_cls_r <= res_cls_nxt;
    out_status_r <= out_status_nxt; out_addr_r <= out_addr_nxt;
    out_copy_r <= out_copy_nxt;     out_cls_r <= out_cls_nxt;
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> state_r == S_CLR)
    else $error("reset did not start the clear pass");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !ram_we)
    else $error("descriptor write outside a request");
  a_split_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SPLIT |-> left_r != '0)
    else $error("split ran with no blocks left");
  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> res_cls_r < CLS_W'(NUM_CLASSES))
    else $error("response class out of range");

endmodule

FILE: bench/tb_size_class_block_allocator_unit.sv
// Testbench for size_class_block_allocator_unit: drives allocate, free and realloc
// requests, predicts every response with an in-bench allocator and checks in order.
// Depends on scba_pkg, scba_if and the allocator RTL.
`timescale 1ns / 1ps

class scba_scoreboard;
  localparam int NCLS = 10;
  localparam int MINB = 32;
  localparam int HDR = 16;
  localparam int CHUNKS = 64;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] addr;
    logic [13:0] copy;
    logic [3:0]  cls;
  } rsp_t;

  int unsigned head[NCLS];
  int unsigned cnt[NCLS];
  int unsigned chunks_used;
  bit [14:0] nxt[32768];
  bit [3:0]  bcls[32768];
  bit [7:0]  used[32768];
  bit        live[32768];
  rsp_t pending_rsp[$];
  int errors;
  int checked;

  function new();
    errors = 0;
    checked = 0;
    chunks_used = 0;
    foreach (head[i]) begin
      head[i] = 0;
      cnt[i] = 0;
    end
    foreach (live[i]) live[i] = 0;
  endfunction

  function longint unsigned cbytes(int c);
    return longint'(MINB) << c;
  endfunction

  function int ushift(int c);
    int s;
    s = 0;
    while (((cbytes(c) - HDR) >> s) > 255) s++;
    return s;
  endfunction

  function int unsigned pop(int c);
    int unsigned idx;
    idx = head[c];
    head[c] = nxt[idx];
    cnt[c]--;
    return idx;
  endfunction

  function void push(int unsigned idx);
    int c;
    c = bcls[idx];
    nxt[idx] = 15'(head[c]);
    head[c] = idx;
    cnt[c]++;
    live[idx] = 0;
  endfunction

  function bit [1:0] alloc(longint unsigned req, output int unsigned idx, output int cls);
    longint unsigned size, bytes, k;
    int c, n;
    int unsigned base;
    bit found;
    size = req + HDR;
    idx = 0;
    cls = 0;
    if (size > cbytes(NCLS - 1)) return scba_pkg::ST_TOO_LARGE;
    c = 0;
    while (c < NCLS - 1 && cbytes(c) < size) c++;
    if (cnt[c] == 0) begin
      found = 0;
      for (n = NCLS - 1; n > c; n--) if (cnt[n] > 0) begin
        found = 1;
        break;
      end
      if (found) begin
        base = pop(n);
        bytes = cbytes(n);
      end else if (chunks_used < CHUNKS) begin
        base = 32'(chunks_used * cbytes(NCLS - 1) / MINB);
        chunks_used++;
        bytes = cbytes(NCLS - 1);
      end else begin
        return scba_pkg::ST_NO_MEM;
      end
      k = bytes / cbytes(c);
      for (longint unsigned i = 0; i < k; i++)
        nxt[base + i * (1 << c)] = (i + 1 < k) ? 15'(base + (i + 1) * (1 << c)) : 15'(0);
      head[c] = base;
      cnt[c] = 32'(k);
    end
    idx = pop(c);
    live[idx] = 1;
    bcls[idx] = 4'(c);
    used[idx] = 8'(req >> ushift(c));
    cls = c;
    return scba_pkg::ST_OK;
  endfunction

  function bit decode(bit [19:0] a, output int unsigned idx);
    idx = 0;
    if (a < HDR || (a - HDR) % MINB != 0) return 0;
    idx = (a - HDR) / MINB;
    return live[idx];
  endfunction

  // Note an accepted request and queue the predicted response.
  function void note_request(bit [1:0] kind, bit [19:0] a, bit [31:0] req);
    rsp_t r;
    int unsigned idx, nidx;
    int cls, oc;
    longint unsigned size, lo, copy, cap;
    r = '0;
    if (kind == scba_pkg::K_ALLOC || (kind == scba_pkg::K_REALLOC && a == 0)) begin
      r.status = alloc(req, nidx, cls);
      if (r.status == scba_pkg::ST_OK) begin
        r.addr = 20'(nidx * MINB + HDR);
        r.cls = 4'(cls);
      end
    end else if (kind == scba_pkg::K_FREE) begin
      if (a != 0) begin
        if (decode(a, idx)) push(idx);
        else r.status = scba_pkg::ST_INVALID;
      end
    end else if (kind == scba_pkg::K_REALLOC) begin
      if (!decode(a, idx)) begin
        r.status = scba_pkg::ST_INVALID;
      end else begin
        oc = bcls[idx];
        size = longint'(req) + HDR;
        lo = oc > 0 ? cbytes(oc - 1) : 0;
        if (size > lo && size <= cbytes(oc)) begin
          used[idx] = 8'(req >> ushift(oc));
          r.addr = a;
          r.cls = 4'(oc);
        end else begin
          r.status = alloc(req, nidx, cls);
          if (r.status == scba_pkg::ST_OK) begin
            cap = cbytes(oc) - HDR;
            copy = (longint'(used[idx]) + 1) << ushift(oc);
            if (copy > cap) copy = cap;
            if (copy > req) copy = req;
            push(idx);
            r.addr = 20'(nidx * MINB + HDR);
            r.copy = 14'(copy);
            r.cls = 4'(cls);
          end
        end
      end
    end
    pending_rsp.push_back(r);
  endfunction

  function void report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endfunction

  function void check_response(bit [1:0] st, bit [19:0] a, bit [13:0] cp, bit [3:0] c);
    rsp_t e;
    if (pending_rsp.size() == 0) begin
      report("response with no request outstanding");
      return;
    end
    e = pending_rsp.pop_front();
    checked++;
    if (st !== e.status) report($sformatf("status %0d exp %0d", st, e.status));
    if (a !== e.addr) report($sformatf("address %h exp %h", a, e.addr));
    if (cp !== e.copy) report($sformatf("copy_bytes %0d exp %0d", cp, e.copy));
    if (c !== e.cls) report($sformatf("size_class %0d exp %0d", c, e.cls));
  endfunction

  // Pick a live user address, or 0 if none.
  function bit [19:0] some_live();
    int unsigned idx;
    for (int t = 0; t < 40; t++) begin
      idx = $urandom_range(0, CHUNKS * 512 - 1);
      if (live[idx]) return 20'(idx * MINB + HDR);
    end
    for (idx = 0; idx < 32768; idx++) if (live[idx]) return 20'(idx * MINB + HDR);
    return 0;
  endfunction
endclass

module tb_size_class_block_allocator_unit;
  import scba_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  int send_idle, recv_stall;
  int idle_cycles;

  scba_req_if in_req();
  scba_rsp_if out_rsp();
  scba_scoreboard sb;

  size_class_block_allocator_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_req(in_req.sink), .out_rsp(out_rsp.source)
  );

  always #10 clk = ~clk;

  // Receiver: random stalls, checks on the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_rsp.valid && out_rsp.ready)
      sb.check_response(out_rsp.status, out_rsp.result_address, out_rsp.copy_bytes,
                        out_rsp.size_class);
  end
  always @(negedge clk) out_rsp.ready <= ($urandom_range(0, 99) >= recv_stall);

  // Watchdog: clearing pass plus longest split and stalls, several times over.
  always @(posedge clk) begin
    if (!rst_n || (in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 200000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Called at a falling edge; valid stays high into the next request when no idle.
  task automatic send_request(bit [1:0] kind, bit [19:0] a, bit [31:0] req);
    while ($urandom_range(0, 99) < send_idle) begin
      in_req.valid <= 0;
      @(negedge clk);
    end
    in_req.valid <= 1;
    in_req.kind <= kind;
    in_req.address <= a;
    in_req.request_size <= req;
    do @(posedge clk); while (!in_req.ready);
    sb.note_request(kind, a, req);
    @(negedge clk);
  endtask

  function automatic bit [31:0] rand_size();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(16300, 16400);
      2: return 32'd1 << $urandom_range(4, 13);
      default: return $urandom_range(0, 1 << $urandom_range(4, 11));
    endcase
  endfunction

  task automatic random_phase(int n);
    int r;
    bit [19:0] a;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      a = sb.some_live();
      if (r < 45) send_request(K_ALLOC, '0, rand_size());
      else if (r < 75) send_request(K_FREE, a, '0);
      else if (r < 92) send_request(K_REALLOC, a, rand_size());
      else if (r < 96) send_request(2'(3), 20'($urandom()), $urandom());
      else send_request(2'($urandom_range(1, 2)), 20'($urandom()), rand_size());
    end
  endtask

  task automatic drain();
    in_req.valid <= 0;
    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    bit [19:0] a;
    in_req.valid = 0;
    in_req.kind = K_ALLOC;
    in_req.address = '0;
    in_req.request_size = '0;
    sb = new();
    send_idle = 0;
    recv_stall = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: extremes, every kind, null and bad addresses, oversize.
    send_request(K_ALLOC, '0, 32'd0);
    send_request(K_ALLOC, '0, 32'd16);
    send_request(K_ALLOC, '0, 32'd17);
    send_request(K_ALLOC, '0, 32'd16368);
    send_request(K_ALLOC, '0, 32'd16369);
    send_request(K_ALLOC, '0, 32'hFFFF_FFFF);
    send_request(K_FREE, '0, '0);
    send_request(K_FREE, 20'd8, '0);
    send_request(K_FREE, 20'd17, '0);
    send_request(K_FREE, 20'hFFFFF, '0);
    send_request(K_REALLOC, '0, 32'd100);
    a = sb.some_live();
    send_request(K_REALLOC, a, 32'd20);
    send_request(K_REALLOC, a, 32'd5000);
    send_request(K_FREE, a, '0);
    send_request(K_FREE, a, '0);
    send_request(K_REALLOC, a, 32'd5);
    a = sb.some_live();
    send_request(K_REALLOC, a, 32'hFFFF_FFFF);
    send_request(2'(3), 20'hFFFFF, 32'hFFFF_FFFF);
    // Exhaust the pool with big blocks.
    for (int i = 0; i < 66; i++) send_request(K_ALLOC, '0, 32'd16000);
    send_request(K_ALLOC, '0, 32'd1);
    for (int i = 0; i < 66; i++) send_request(K_FREE, sb.some_live(), '0);
    drain();

    random_phase(60);
    send_idle = 71;
    random_phase(80);
    send_idle = 0;
    recv_stall = 71;
    random_phase(80);
    send_idle = 24;
    recv_stall = 24;
    random_phase(80);
    send_idle = 0;
    recv_stall = 0;
    drain();

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
